@@ hw/rtl/bsl_pkg.sv @@
// Shared types and constants for the styled line rasterizer.
package bsl_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int PAT_BITS       = 4;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STYLE_SIMPLE = 2'd0,
        STYLE_DASHED = 2'd1,
        STYLE_DOTTED = 2'd2,
        STYLE_THICK  = 2'd3
    } t_style;

    localparam logic [3:0] SIZE_NORMAL      = 4'd4;
    localparam logic [3:0] SIZE_THICK_START = 4'd7;
    localparam logic [3:0] SIZE_THICK       = 4'd8;

    localparam logic [PAT_BITS-1:0] PAT_START  = 4'd1;
    localparam logic [PAT_BITS-1:0] DASH_ON    = 4'd6;
    localparam logic [PAT_BITS-1:0] DASH_WRAP  = 4'd12;
    localparam logic [PAT_BITS-1:0] DOT_PERIOD = 4'd10;

    // Pattern unit result: plot flag and next pattern count.
    typedef struct packed {
        logic                plot;
        logic [PAT_BITS-1:0] count;
    } t_pat;

endpackage

@@ hw/rtl/bresenham_styled_line.sv @@
// Top level of the styled Bresenham line rasterizer.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one transaction per item:
//   i_operation = start (load endpoints and style, emit the start point)
//   or step (advance x by one, maybe y, emit the new point).
//   Output channel (o_valid / i_stall) carries one pixel per input item:
//   position, plot flag under the dash/dot pattern, point size, line done.
// Path: the input register loads at the accepting edge; the result register,
//   and o_valid with it, loads when the item advances, which i_stall on a full result register delays.
//   Throughput: one item per cycle while i_stall is low; the line state
//   update is one add, saturate and compare on the decision path.
// Stall: when i_stall holds a full result register, the input register
//   keeps its item and o_stall rises only if both stages are full, so a
//   new transaction is still taken while a finished pixel waits.
// Reset: i_rst_n low at a clock edge empties both stages and zeroes the
//   line state; a step before any start reports point (0,0), line done.
// A step past the end holds x and y, plots nothing and flags line done.
module bresenham_styled_line #(
    parameter int COORD_BITS = bsl_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    input  logic [1:0]                   i_style,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS+1:0] o_pixel_y,
    output logic                         o_plot,
    output logic [3:0]                   o_point_size,
    output logic                         o_line_done
);
    import bsl_pkg::*;

    // input stage
    logic                         r_in_valid;
    logic                         r_in_op;
    logic signed [COORD_BITS-1:0] r_in_xs, r_in_ys, r_in_xe, r_in_ye;
    logic [1:0]                   r_in_style;

    // line state
    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic signed [COORD_BITS+1:0] r_cur_y, n_cur_y;
    logic signed [COORD_BITS-1:0] r_end_x, n_end_x;
    logic signed [COORD_BITS+4:0] r_dec, n_dec;
    logic signed [COORD_BITS+1:0] r_inc_flat, n_inc_flat;
    logic signed [COORD_BITS+2:0] r_inc_diag, n_inc_diag;
    logic [1:0]                   r_style, n_style;
    logic [PAT_BITS-1:0]          r_pat_count;

    // result stage
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS+1:0] r_py;
    logic                         r_plot;
    logic [3:0]                   r_size, n_size;
    logic                         r_done;

    logic   w_start;
    logic   w_moved;
    logic   w_done;
    logic   w_advance;
    logic   w_in_take;
    t_pat   w_pat;

    // the input stage moves on when the result stage is free or draining
    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_in_take = i_valid && !o_stall;
    assign w_start   = (r_in_op == OP_START);

    bsl_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .i_start    (w_start),
        .i_x_start  (r_in_xs),
        .i_y_start  (r_in_ys),
        .i_x_end    (r_in_xe),
        .i_y_end    (r_in_ye),
        .i_cur_x    (r_cur_x),
        .i_cur_y    (r_cur_y),
        .i_end_x    (r_end_x),
        .i_dec      (r_dec),
        .i_inc_flat (r_inc_flat),
        .i_inc_diag (r_inc_diag),
        .o_cur_x    (n_cur_x),
        .o_cur_y    (n_cur_y),
        .o_end_x    (n_end_x),
        .o_dec      (n_dec),
        .o_inc_flat (n_inc_flat),
        .o_inc_diag (n_inc_diag),
        .o_moved    (w_moved),
        .o_done     (w_done)
    );

    // pattern runs on the stored style; a start item reloads it
    bsl_pattern u_pattern (
        .i_start (w_start),
        .i_moved (w_moved),
        .i_style (r_style),
        .i_count (r_pat_count),
        .o_pat   (w_pat)
    );

    assign n_style = w_start ? r_in_style : r_style;

    always_comb begin
        if (w_start) begin
            n_size = (r_in_style == STYLE_THICK) ? SIZE_THICK_START : SIZE_NORMAL;
        end else begin
            n_size = (r_style == STYLE_THICK) ? SIZE_THICK : SIZE_NORMAL;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op    <= i_operation;
            r_in_xs    <= i_x_start;
            r_in_ys    <= i_y_start;
            r_in_xe    <= i_x_end;
            r_in_ye    <= i_y_end;
            r_in_style <= i_style;
        end
    end

    // line state, updated as each item retires into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_end_x     <= '0;
            r_dec       <= '0;
            r_inc_flat  <= '0;
            r_inc_diag  <= '0;
            r_style     <= '0;
            r_pat_count <= '0;
        end else if (w_advance) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_end_x     <= n_end_x;
            r_dec       <= n_dec;
            r_inc_flat  <= n_inc_flat;
            r_inc_diag  <= n_inc_diag;
            r_style     <= n_style;
            r_pat_count <= w_pat.count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_px   <= n_cur_x;
            r_py   <= n_cur_y;
            r_plot <= w_pat.plot;
            r_size <= n_size;
            r_done <= w_done;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_plot       = r_plot;
    assign o_point_size = r_size;
    assign o_line_done  = r_done;

`ifndef SYNTHESIS
    // a start point is always drawn
    a_start_plots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_start) |=> o_plot)
        else $error("start point not plotted");

    // the dash counter never reaches its wrap value
    a_dash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_style == STYLE_DASHED) |-> (r_pat_count < DASH_WRAP))
        else $error("dash counter out of range");

    // the dot counter stays inside one period
    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_style == STYLE_DOTTED) |-> (r_pat_count < DOT_PERIOD))
        else $error("dot counter out of range");

    // a step that leaves x unchanged plots nothing
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_start && !w_moved) |=> (!o_plot && o_line_done))
        else $error("step past end plotted");
`endif

endmodule

@@ hw/rtl/bsl_pattern.sv @@
// Style pattern logic: plot decision and pattern counter update.
module bsl_pattern (
    input  logic                         i_start,
    input  logic                         i_moved,
    input  logic [1:0]                   i_style,
    input  logic [bsl_pkg::PAT_BITS-1:0] i_count,
    output bsl_pkg::t_pat                o_pat
);
    import bsl_pkg::*;

    logic [PAT_BITS:0]   w_cnt;
    logic [PAT_BITS:0]   w_p1;
    logic [PAT_BITS:0]   w_p2;
    logic [PAT_BITS-1:0] w_mod;

    assign w_cnt = {1'b0, i_count};

    always_comb begin
        // dashed: draw below DASH_ON, then run the off phase up to the wrap
        w_p1 = (i_count < DASH_ON) ? w_cnt + 5'd1 : w_cnt;
        w_p2 = w_p1;
        if (w_p1 >= {1'b0, DASH_ON}) begin
            w_p2 = w_p1 + 5'd1;
            if (w_p2 >= {1'b0, DASH_WRAP}) begin
                w_p2 = '0;
            end
        end
        // dotted: count modulo the dot period
        w_mod = (i_count >= DOT_PERIOD) ? i_count - DOT_PERIOD : i_count;
    end

    always_comb begin
        o_pat.plot  = 1'b0;
        o_pat.count = i_count;
        if (i_start) begin
            o_pat.plot  = 1'b1;
            o_pat.count = PAT_START;
        end else if (i_moved) begin
            case (i_style)
                STYLE_DASHED: begin
                    o_pat.plot  = (i_count < DASH_ON);
                    o_pat.count = w_p2[PAT_BITS-1:0];
                end
                STYLE_DOTTED: begin
                    o_pat.plot  = (w_mod == '0);
                    o_pat.count = (w_mod == DOT_PERIOD - 4'd1) ? '0 : w_mod + 4'd1;
                end
                default: begin
                    o_pat.plot = 1'b1;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/bsl_step.sv @@
// Position and decision update: line setup on start, one Bresenham step otherwise.
module bsl_step #(
    parameter int COORD_BITS = bsl_pkg::COORD_BITS_DEF
) (
    input  logic                         i_start,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    input  logic signed [COORD_BITS-1:0] i_cur_x,
    input  logic signed [COORD_BITS+1:0] i_cur_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS+4:0] i_dec,
    input  logic signed [COORD_BITS+1:0] i_inc_flat,
    input  logic signed [COORD_BITS+2:0] i_inc_diag,
    output logic signed [COORD_BITS-1:0] o_cur_x,
    output logic signed [COORD_BITS+1:0] o_cur_y,
    output logic signed [COORD_BITS-1:0] o_end_x,
    output logic signed [COORD_BITS+4:0] o_dec,
    output logic signed [COORD_BITS+1:0] o_inc_flat,
    output logic signed [COORD_BITS+2:0] o_inc_diag,
    output logic                         o_moved,
    output logic                         o_done
);
    localparam int DB = COORD_BITS + 5;

    logic signed [COORD_BITS:0]   w_dx;
    logic signed [COORD_BITS:0]   w_dy;
    logic signed [COORD_BITS+1:0] w_dmd;
    logic signed [COORD_BITS+2:0] w_dec0;
    logic signed [DB:0]           w_inc;
    logic signed [DB:0]           w_sum;
    logic signed [DB-1:0]         w_sat;
    logic                         w_neg;

    // line setup
    assign w_dx   = {i_x_end[COORD_BITS-1], i_x_end} - {i_x_start[COORD_BITS-1], i_x_start};
    assign w_dy   = {i_y_end[COORD_BITS-1], i_y_end} - {i_y_start[COORD_BITS-1], i_y_start};
    assign w_dmd  = {w_dy[COORD_BITS], w_dy} - {w_dx[COORD_BITS], w_dx};
    assign w_dec0 = {w_dy[COORD_BITS], w_dy, 1'b0} - {{2{w_dx[COORD_BITS]}}, w_dx};

    // step: pick increment by decision sign, add and saturate
    assign o_moved = !i_start && (i_cur_x < i_end_x);
    assign w_neg   = i_dec[DB-1];
    assign w_inc   = w_neg ? {{4{i_inc_flat[COORD_BITS+1]}}, i_inc_flat}
                           : {{3{i_inc_diag[COORD_BITS+2]}}, i_inc_diag};
    assign w_sum   = {i_dec[DB-1], i_dec} + w_inc;

    always_comb begin
        if (w_sum[DB] != w_sum[DB-1]) begin
            w_sat = w_sum[DB] ? {1'b1, {(DB-1){1'b0}}} : {1'b0, {(DB-1){1'b1}}};
        end else begin
            w_sat = w_sum[DB-1:0];
        end
    end

    always_comb begin
        o_cur_x    = i_cur_x;
        o_cur_y    = i_cur_y;
        o_end_x    = i_end_x;
        o_dec      = i_dec;
        o_inc_flat = i_inc_flat;
        o_inc_diag = i_inc_diag;
        if (i_start) begin
            o_cur_x    = i_x_start;
            o_cur_y    = {{2{i_y_start[COORD_BITS-1]}}, i_y_start};
            o_end_x    = i_x_end;
            o_dec      = {{2{w_dec0[COORD_BITS+2]}}, w_dec0};
            o_inc_flat = {w_dy, 1'b0};
            o_inc_diag = {w_dmd, 1'b0};
        end else if (o_moved) begin
            o_cur_x = i_cur_x + {{(COORD_BITS-1){1'b0}}, 1'b1};
            o_cur_y = i_cur_y + {{(COORD_BITS+1){1'b0}}, !w_neg};
            o_dec   = w_sat;
        end
    end

    assign o_done = (o_cur_x >= o_end_x);

endmodule

@@ test/tb_bresenham_styled_line.sv @@
// Self-checking testbench for the styled Bresenham line rasterizer.
`timescale 1ns / 100ps

module tb_bresenham_styled_line;
    import bsl_pkg::*;

    localparam int CB             = COORD_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
    localparam int HOLD_CYCLES    = 60;    // long output hold-off for the fill-up test
    localparam int DRAIN_CYCLES   = 8;     // two pipeline stages plus margin
    localparam int DEC_MAX        = (1 << (CB + 4)) - 1;
    localparam int DEC_MIN        = -(1 << (CB + 4));

    // One output pixel, at the port widths.
    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB+1:0] y;
        logic                 plot;
        logic [3:0]           size;
        logic                 done;
    } t_pixel;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_operation;
    logic signed [CB-1:0] i_x_start;
    logic signed [CB-1:0] i_y_start;
    logic signed [CB-1:0] i_x_end;
    logic signed [CB-1:0] i_y_end;
    logic [1:0]           i_style;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [CB-1:0] o_pixel_x;
    logic signed [CB+1:0] o_pixel_y;
    logic                 o_plot;
    logic [3:0]           o_point_size;
    logic                 o_line_done;

    bresenham_styled_line #(.COORD_BITS(CB)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_style      (i_style),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_plot       (o_plot),
        .o_point_size (o_point_size),
        .o_line_done  (o_line_done)
    );

    // Expected pixels, oldest first.
    t_pixel exp_pixels[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int idle_run       = 0;

    // Idling knobs, in percent per cycle.
    int send_idle_pct  = 0;
    int stall_pct      = 0;

    // Output hold-off request; the stall process owns the countdown.
    bit hold_req       = 1'b0;
    int hold_left      = 0;

    // Line state mirrored by the predictor. Plain ints: every value fits,
    // and the decision is clamped to its register width by hand.
    int     ln_x     = 0;
    int     ln_y     = 0;
    int     ln_end   = 0;
    int     ln_dec   = 0;
    int     ln_flat  = 0;
    int     ln_diag  = 0;
    t_style ln_style = STYLE_SIMPLE;
    int     ln_count = 0;

    //------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic int sat_decision(longint v);
        if (v > DEC_MAX) return DEC_MAX;
        if (v < DEC_MIN) return DEC_MIN;
        return int'(v);
    endfunction

    // Advances the mirrored line state by one transaction and returns the
    // pixel the block should report for it.
    function automatic t_pixel next_pixel(t_op op, int xs, int ys, int xe, int ye,
                                          t_style sty);
        t_pixel p;
        int     dx;
        int     dy;
        p.plot = 1'b0;
        p.size = SIZE_NORMAL;
        if (op == OP_START) begin
            dx       = xe - xs;
            dy       = ye - ys;
            ln_x     = xs;
            ln_y     = ys;
            ln_end   = xe;
            ln_dec   = sat_decision(2 * longint'(dy) - dx);
            ln_flat  = 2 * dy;
            ln_diag  = 2 * (dy - dx);
            ln_style = sty;
            ln_count = int'(PAT_START);
            p.plot   = 1'b1;
            p.size   = (sty == STYLE_THICK) ? SIZE_THICK_START : SIZE_NORMAL;
        end else begin
            p.size = (ln_style == STYLE_THICK) ? SIZE_THICK : SIZE_NORMAL;
            // Past the end (or before any start): position holds, nothing plots.
            if (ln_x < ln_end) begin
                ln_x++;
                if (ln_dec < 0) begin
                    ln_dec = sat_decision(longint'(ln_dec) + ln_flat);
                end else begin
                    ln_y++;
                    ln_dec = sat_decision(longint'(ln_dec) + ln_diag);
                end
                case (ln_style)
                    STYLE_DASHED: begin
                        // Draw while below the on-length, then count through the gap.
                        if (ln_count < int'(DASH_ON)) begin
                            p.plot = 1'b1;
                            ln_count++;
                        end
                        if (ln_count >= int'(DASH_ON)) begin
                            ln_count++;
                            if (ln_count >= int'(DASH_WRAP)) ln_count = 0;
                        end
                    end
                    STYLE_DOTTED: begin
                        ln_count = ln_count % int'(DOT_PERIOD);
                        p.plot   = (ln_count == 0);
                        ln_count = (ln_count + 1) % int'(DOT_PERIOD);
                    end
                    default: p.plot = 1'b1;
                endcase
            end
        end
        p.x    = ln_x[CB-1:0];
        p.y    = ln_y[CB+1:0];
        p.done = (ln_x >= ln_end);
        return p;
    endfunction

    //------------------------------------------------------------------
    // Input side: one transaction per call, with random idle cycles before
    // it. Fields change on the falling edge; acceptance is seen at the
    // rising edge, and only then is the expected pixel worked out.
    //------------------------------------------------------------------
    task automatic send_item(t_op op, logic signed [CB-1:0] xs, logic signed [CB-1:0] ys,
                             logic signed [CB-1:0] xe, logic signed [CB-1:0] ye,
                             t_style sty);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_x_start   <= xs;
        i_y_start   <= ys;
        i_x_end     <= xe;
        i_y_end     <= ye;
        i_style     <= sty;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        exp_pixels.push_back(next_pixel(op, int'(xs), int'(ys), int'(xe), int'(ye), sty));
        items_sent++;
    endtask

    task automatic start_line(int xs, int ys, int xe, int ye, t_style sty);
        send_item(OP_START, CB'(xs), CB'(ys), CB'(xe), CB'(ye), sty);
    endtask

    // Step transactions carry random endpoint and style bits; the block must
    // ignore them.
    task automatic step_line(int n);
        repeat (n) send_item(OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom),
                             CB'($urandom), t_style'($urandom_range(3)));
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Stops offering input, then waits for every expected pixel.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (exp_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    //------------------------------------------------------------------
    // Output side: random stall, plus the long hold-off when requested.
    //------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Every accepted pixel is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_pixels.size() == 0) begin
                $error("pixel transaction with no expectation pending");
                mismatch_count++;
            end else begin
                want = exp_pixels.pop_front();
                check_field("pixel_x",    int'(want.x),    int'(o_pixel_x));
                check_field("pixel_y",    int'(want.y),    int'(o_pixel_y));
                check_field("plot",       int'(want.plot), int'(o_plot));
                check_field("point_size", int'(want.size), int'(o_point_size));
                check_field("line_done",  int'(want.done), int'(o_line_done));
            end
        end
    end

    // Watchdog: a run of cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // A step straight out of reset reports (0,0), finished, nothing drawn.
    task automatic test_step_after_reset();
        step_line(1);
    endtask

    // Corner-to-corner lines at the coordinate extremes, both diagonals.
    task automatic test_extremes();
        start_line(-2048, -2048, 2047, 2047, STYLE_THICK);
        step_line(2);
        start_line(-2048, 2047, 2047, -2048, STYLE_DOTTED);
        step_line(3);
    endtask

    // End left of start finishes at once; a single-point line too.
    task automatic test_degenerate_lines();
        start_line(2047, 2047, -2048, -2048, STYLE_SIMPLE);
        step_line(1);
        start_line(5, 5, 5, 5, STYLE_DASHED);
        step_line(1);
    endtask

    // Steep and shallow lines; the steep one is run past its end.
    task automatic test_short_lines();
        start_line(0, 0, 3, -2047, STYLE_DASHED);
        step_line(4);
        start_line(0, 0, 10, 3, STYLE_SIMPLE);
        step_line(3);
    endtask

    // Hold the output off for a long stretch while input keeps coming, so
    // both stages fill and the block pushes back on its input.
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_req = 1'b1;
        start_line(-100, 40, -70, 55, STYLE_DASHED);
        step_line(34);
        wait_drained();
    endtask

    // Mostly well-formed lines with random content; the rest full-range
    // endpoints and loose noise transactions.
    task automatic test_random_lines(int n_items);
        int goal;
        int kind;
        int xs;
        int xe;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                xs = $urandom_range(4095) - 2048;
                xe = xs + $urandom_range(40);
                if (xe > 2047) xe = 2047;
                start_line(xs, $urandom_range(4095) - 2048, xe,
                           $urandom_range(4095) - 2048, t_style'($urandom_range(3)));
                step_line($urandom_range(xe - xs + 3));
            end else if (kind < 85) begin
                start_line($urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                           $urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                           t_style'($urandom_range(3)));
                step_line($urandom_range(30));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(t_op'($urandom_range(1)), CB'($urandom), CB'($urandom),
                              CB'($urandom), CB'($urandom), t_style'($urandom_range(3)));
            end
        end
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_operation = OP_START;
        i_x_start   = '0;
        i_y_start   = '0;
        i_x_end     = '0;
        i_y_end     = '0;
        i_style     = STYLE_SIMPLE;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0, 0);
        test_step_after_reset();
        test_extremes();
        test_degenerate_lines();
        test_short_lines();
        wait_drained();

        test_backpressure();

        // Random part across the idling mixes.
        set_idling(0, 0);
        test_random_lines(120);
        set_idling(78, 0);
        test_random_lines(120);
        set_idling(0, 78);
        test_random_lines(120);
        set_idling(25, 25);
        test_random_lines(120);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ bresenham_styled_line.f @@
hw/rtl/bsl_pkg.sv
hw/rtl/bsl_pattern.sv
hw/rtl/bsl_step.sv
hw/rtl/bresenham_styled_line.sv
test/tb_bresenham_styled_line.sv
